/* rtl/set_assoc_cache_lru_sim_core_defines.svh */
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim_core_defines
// assertion macros shared by the cache model rtl
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_LRU_SIM_CORE_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_SIM_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SACL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define SACL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SACL_ASSERT_IMP(lbl, ante, cons)
`define SACL_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* rtl/sacl_pkg.sv */
// ----------------------------------------------------------------------------
// sacl_pkg
// shared types and constants of the set-associative cache model
// ----------------------------------------------------------------------------
package sacl_pkg;

    localparam int TOT_W = 32;
    localparam int APB_AW = 4;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_SET_BITS   = 2'd0;
    localparam t_reg_idx REG_WAYS       = 2'd1;
    localparam t_reg_idx REG_BLOCK_BITS = 2'd2;

    typedef logic [1:0] t_func;
    localparam t_func FUNC_MODIFY = 2'd2;
    localparam t_func FUNC_NONE   = 2'd3;

    typedef struct packed {
        logic [2:0] set_bits;
        logic [3:0] ways;
        logic [4:0] block_bits;
    } t_cfg;

    typedef struct packed {
        logic hit;
        logic miss;
        logic evicted;
    } t_flags;

endpackage

/* rtl/sacl_req_if.sv */
// ----------------------------------------------------------------------------
// sacl_req_if
// access request channel: kind and byte address
// ----------------------------------------------------------------------------
interface sacl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] address;

    modport source (output valid, output func, output address, input ready);
    modport sink (input valid, input func, input address, output ready);
endinterface

/* rtl/sacl_rsp_if.sv */
// ----------------------------------------------------------------------------
// sacl_rsp_if
// access result channel: lookup flags and running totals
// ----------------------------------------------------------------------------
interface sacl_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic        miss;
    logic        evicted;
    logic [31:0] total_hits;
    logic [31:0] total_misses;
    logic [31:0] total_evictions;

    modport source (output valid, output hit, output miss, output evicted,
                    output total_hits, output total_misses, output total_evictions,
                    input ready);
    modport sink (input valid, input hit, input miss, input evicted,
                  input total_hits, input total_misses, input total_evictions,
                  output ready);
endinterface

/* rtl/set_assoc_cache_lru_sim_core.sv */
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim_core
// tag-only set-associative cache model with lru replacement and totals
// ----------------------------------------------------------------------------
// The set row is read from the single set memory into a read register in the
// accept cycle and, in the update state, written back with updated tags, valid
// bits and lru ranks, except for FUNC_NONE, when the result is loaded into the
// output register. The next request is taken while that result waits; the
// write-back of a later request waits until the output register is free. After
// reset a clearing pass runs through every row of the set memory, during which
// no request is taken; configuration writes are taken at all times.
`include "set_assoc_cache_lru_sim_core_defines.svh"

module set_assoc_cache_lru_sim_core
    import sacl_pkg::*;
#(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_WIDTH   = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sacl_req_if.sink          i_req,
    sacl_rsp_if.source        o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int AW    = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
    localparam int SW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int ROWS  = 1 << MAX_SET_BITS;
    localparam int RW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int ROW_W = MAX_WAYS * (1 + AW + RW);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_UPDATE = 1'b1;

    t_cfg               cfg;
    logic               r_state, n_state;
    logic               accept, update_go, clr_busy, wr_en;
    logic [3:0]         sb;
    logic [5:0]         shamt;
    logic [4:0]         nw;
    logic [AW-1:0]      addr_eff, sh_b, tag_in;
    logic [SW-1:0]      set_in;
    logic [MAX_WAYS-1:0] inuse;
    logic [ROW_W-1:0]   rd_row, wr_row;
    t_flags             upd_flags;

    logic [AW-1:0]      r_tag;
    logic [SW-1:0]      r_set;
    t_func              r_func;
    logic               r_out_valid;
    t_flags             r_flags;
    logic [TOT_W-1:0]   r_hits, r_misses, r_evicts;
    logic [TOT_W-1:0]   n_hits, n_misses, n_evicts, hits_1;

    function automatic logic [TOT_W-1:0] sat_inc(input logic [TOT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    sacl_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // address split and clamped configuration
    always_comb begin
        sb       = (4'(cfg.set_bits) > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS)
                                                         : 4'(cfg.set_bits);
        shamt    = 6'(sb) + 6'(cfg.block_bits);
        addr_eff = i_req.address[AW-1:0];
        tag_in   = addr_eff >> shamt;
        sh_b     = addr_eff >> cfg.block_bits;
        set_in   = SW'(sh_b);
        for (int k = 0; k < SW; k++) begin
            if (4'(k) >= sb) begin
                set_in[k] = 1'b0;
            end
        end
        if (cfg.ways == 4'd0) begin
            nw = 5'd1;
        end else if (5'(cfg.ways) > 5'(MAX_WAYS)) begin
            nw = 5'(MAX_WAYS);
        end else begin
            nw = 5'(cfg.ways);
        end
        for (int i = 0; i < MAX_WAYS; i++) begin
            inuse[i] = 5'(i) < nw;
        end
    end

    assign i_req.ready = (r_state == ST_IDLE) && !clr_busy;
    assign accept      = i_req.valid && i_req.ready;
    assign update_go   = (r_state == ST_UPDATE) && (!r_out_valid || o_rsp.ready);
    assign wr_en       = update_go && (r_func != FUNC_NONE);

    sacl_set_mem #(
        .ROWS  (ROWS),
        .SW    (SW),
        .ROW_W (ROW_W)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_addr  (set_in),
        .o_rd_data  (rd_row),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_set),
        .i_wr_data  (wr_row),
        .o_clr_busy (clr_busy)
    );

    sacl_update #(
        .MAX_WAYS (MAX_WAYS),
        .AW       (AW),
        .RW       (RW)
    ) u_upd (
        .i_row   (rd_row),
        .i_tag   (r_tag),
        .i_inuse (inuse),
        .o_row   (wr_row),
        .o_flags (upd_flags)
    );

    always_comb begin
        n_state  = r_state;
        n_hits   = r_hits;
        n_misses = r_misses;
        n_evicts = r_evicts;
        hits_1   = upd_flags.hit ? sat_inc(r_hits) : r_hits;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (update_go) begin
                    n_state = ST_IDLE;
                    if (r_func != FUNC_NONE) begin
                        n_hits   = (r_func == FUNC_MODIFY) ? sat_inc(hits_1) : hits_1;
                        n_misses = upd_flags.miss ? sat_inc(r_misses) : r_misses;
                        n_evicts = upd_flags.evicted ? sat_inc(r_evicts) : r_evicts;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
        end else begin
            r_state  <= n_state;
            r_hits   <= n_hits;
            r_misses <= n_misses;
            r_evicts <= n_evicts;
            if (update_go) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tag  <= tag_in;
            r_set  <= set_in;
            r_func <= i_req.func;
        end
        if (update_go) begin
            r_flags <= (r_func == FUNC_NONE) ? '0 : upd_flags;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.hit             = r_flags.hit;
    assign o_rsp.miss            = r_flags.miss;
    assign o_rsp.evicted         = r_flags.evicted;
    assign o_rsp.total_hits      = r_hits;
    assign o_rsp.total_misses    = r_misses;
    assign o_rsp.total_evictions = r_evicts;

    `SACL_ASSERT_NXT(a_accept_to_update, accept, r_state == ST_UPDATE)
    `SACL_ASSERT_NXT(a_update_gives_result, update_go, r_out_valid)
    `SACL_ASSERT_IMP(a_flags_consistent, r_out_valid, !(r_flags.hit && r_flags.miss) && (!r_flags.evicted || r_flags.miss))
    `SACL_ASSERT_IMP(a_clear_nothing_in_flight, clr_busy, (r_state == ST_IDLE) && !r_out_valid)

endmodule

/* rtl/sacl_cfg_regs.sv */
// ----------------------------------------------------------------------------
// sacl_cfg_regs
// apb configuration registers: set bits, ways, block bits
// ----------------------------------------------------------------------------
module sacl_cfg_regs
    import sacl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;

    assign idx    = paddr[3:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_bits   <= 3'd0;
            r_cfg.ways       <= 4'd1;
            r_cfg.block_bits <= 5'd0;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_SET_BITS:   r_cfg.set_bits   <= pwdata[2:0];
                REG_WAYS:       r_cfg.ways       <= pwdata[3:0];
                REG_BLOCK_BITS: r_cfg.block_bits <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_SET_BITS:   prdata = {29'd0, r_cfg.set_bits};
            REG_WAYS:       prdata = {28'd0, r_cfg.ways};
            REG_BLOCK_BITS: prdata = {27'd0, r_cfg.block_bits};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

/* rtl/sacl_set_mem.sv */
// ----------------------------------------------------------------------------
// sacl_set_mem
// set memory, one row per set, registered read, clearing pass after reset
// ----------------------------------------------------------------------------
module sacl_set_mem
    import sacl_pkg::*;
#(
    parameter int ROWS  = 64,
    parameter int SW    = 6,
    parameter int ROW_W = 288
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [SW-1:0]    i_rd_addr,
    output logic [ROW_W-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [SW-1:0]    i_wr_addr,
    input  logic [ROW_W-1:0] i_wr_data,
    output logic             o_clr_busy
);

    logic [ROW_W-1:0] r_mem [ROWS];
    logic [ROW_W-1:0] r_rd_data;
    logic             r_clr_busy;
    logic [SW-1:0]    r_clr_idx;
    logic             wr_en;
    logic [SW-1:0]    wr_addr;
    logic [ROW_W-1:0] wr_data;

    assign o_rd_data  = r_rd_data;
    assign o_clr_busy = r_clr_busy;
    assign wr_en      = r_clr_busy || i_wr_en;
    assign wr_addr    = r_clr_busy ? r_clr_idx : i_wr_addr;
    assign wr_data    = r_clr_busy ? '0 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_idx == SW'(ROWS - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

/* rtl/sacl_update.sv */
// ----------------------------------------------------------------------------
// sacl_update
// tag search, victim choice and lru rank update over one set row
// ----------------------------------------------------------------------------
module sacl_update
    import sacl_pkg::*;
#(
    parameter int MAX_WAYS = 8,
    parameter int AW       = 32,
    parameter int RW       = 3
) (
    input  logic [MAX_WAYS*(1+AW+RW)-1:0] i_row,
    input  logic [AW-1:0]                 i_tag,
    input  logic [MAX_WAYS-1:0]           i_inuse,
    output logic [MAX_WAYS*(1+AW+RW)-1:0] o_row,
    output t_flags                        o_flags
);

    localparam int EW = 1 + AW + RW;
    localparam logic [RW-1:0] RANK_TOP = RW'(MAX_WAYS - 1);

    logic [MAX_WAYS-1:0]         vld, vld_n, match, free, best;
    logic [MAX_WAYS-1:0][AW-1:0] tg, tg_n;
    logic [MAX_WAYS-1:0][RW-1:0] rk, rk_n;
    logic                        hit, any_free;
    logic [RW-1:0]               way, old_rank;

    function automatic logic [RW-1:0] first_one(input logic [MAX_WAYS-1:0] vec);
        logic [RW-1:0] pos;
        pos = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (vec[i]) begin
                pos = RW'(i);
            end
        end
        return pos;
    endfunction

    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            vld[i]   = i_row[i*EW + EW - 1];
            tg[i]    = i_row[i*EW + RW +: AW];
            rk[i]    = i_row[i*EW +: RW];
            match[i] = i_inuse[i] && vld[i] && (tg[i] == i_tag);
            free[i]  = i_inuse[i] && !vld[i];
        end
    end

    // oldest in-use way, lowest index on a tie
    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            best[i] = i_inuse[i];
            for (int j = 0; j < MAX_WAYS; j++) begin
                if (i_inuse[j] && ((j < i) ? (rk[j] >= rk[i]) : (rk[j] > rk[i]))) begin
                    best[i] = 1'b0;
                end
            end
        end
    end

    assign hit      = |match;
    assign any_free = |free;
    assign way      = hit ? first_one(match) : (any_free ? first_one(free) : first_one(best));
    assign old_rank = rk[way];

    always_comb begin
        vld_n = vld;
        tg_n  = tg;
        rk_n  = rk;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (RW'(i) != way && i_inuse[i] && vld[i] && (!hit || rk[i] < old_rank)
                && rk[i] < RANK_TOP) begin
                rk_n[i] = rk[i] + 1'b1;
            end
        end
        rk_n[way] = '0;
        if (!hit) begin
            vld_n[way] = 1'b1;
            tg_n[way]  = i_tag;
        end
        for (int i = 0; i < MAX_WAYS; i++) begin
            o_row[i*EW +: EW] = {vld_n[i], tg_n[i], rk_n[i]};
        end
    end

    assign o_flags.hit     = hit;
    assign o_flags.miss    = !hit;
    assign o_flags.evicted = !hit && !any_free;

endmodule
